// File: rtl/core/max_heap_priority_queue_assert.svh
// Assertion macros used by the priority queue top module.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define MHPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define MHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MHPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define MHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/mhpq_pkg.sv
// Shared types and constants for the priority queue.
package mhpq_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VALUE_W      = 32;
  localparam int COUNT_OUT_W  = 6;

  // Operation codes carried on the input tuser
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_e;

  // Operation broadcast to every cell
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic signed [VALUE_W-1:0] value;
  } cell_op_t;

endpackage

// File: rtl/core/max_heap_priority_queue.sv
// Max priority queue over signed 32-bit values, built as a sorted chain of cells.
// The result of each accepted item is loaded into the output register on accept.
// Throughput: one item per cycle while m_tready does not hold the output; every cell
// compares against the broadcast value and shifts together, so the rate does not depend on CAPACITY.
// Reset clears the entry count and the output valid; cell contents are left as is.
`include "max_heap_priority_queue_assert.svh"
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] value
  input  logic        s_tuser,  // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // [31:0] removed_value, [37:32] entry_count,
                                // [69:38] top_value, [71:70] zero
  output logic [1:0]  m_tuser   // [1:0] status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic                      in_acc;
  logic                      full, empty;
  cell_op_t                  op;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CAPACITY-1:0]       occ, ge;
  logic signed [VALUE_W-1:0] val_q [CAPACITY];
  logic signed [VALUE_W-1:0] val_d [CAPACITY];

  logic                      out_valid_q;
  status_e                   status_q, status_d;
  logic signed [VALUE_W-1:0] removed_q, removed_d;
  logic signed [VALUE_W-1:0] top_q, top_d;
  logic [COUNT_OUT_W-1:0]    cnt_out_q;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  // Accept while the output register is free or being drained
  assign s_tready = !out_valid_q || m_tready;
  assign in_acc   = s_tvalid && s_tready;
  assign full     = (count_q == CAP_CNT);
  assign empty    = (count_q == '0);

  // Decode the operation; rejected ones leave the chain untouched
  always_comb begin
    op.value = signed'(s_tdata);
    op.ins   = in_acc && (s_tuser == KIND_INSERT) && !full;
    op.del   = in_acc && (s_tuser == KIND_DELETE) && !empty;
  end

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                      lge;
    logic signed [VALUE_W-1:0] lval, rval;

    assign occ[i] = (IDX < count_q);
    if (i == 0) begin : g_first
      assign lge  = 1'b1;
      assign lval = val_q[i];
    end else begin : g_mid
      assign lge  = ge[i-1];
      assign lval = val_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rval = val_q[i];
    end else begin : g_inner
      assign rval = val_q[i+1];
    end

    mhpq_cell u_cell (
      .clk_i      (clk_i),
      .occ_i      (occ[i]),
      .op_i       (op),
      .left_ge_i  (lge),
      .left_val_i (lval),
      .right_val_i(rval),
      .ge_o       (ge[i]),
      .val_q_o    (val_q[i]),
      .val_d_o    (val_d[i])
    );
  end

  // Count update and result of this item
  always_comb begin
    count_d   = count_q;
    status_d  = STATUS_DONE;
    removed_d = '0;
    if (op.ins) begin
      count_d = count_q + 1'b1;
    end else if (op.del) begin
      count_d   = count_q - 1'b1;
      removed_d = val_q[0];
    end else if (s_tuser == KIND_INSERT) begin
      status_d = STATUS_OVERFLOW;
    end else begin
      status_d = STATUS_EMPTY;
    end
    top_d   = (count_d != '0) ? val_d[0] : '0;
    cnt_ext = {{COUNT_OUT_W{1'b0}}, count_d};
  end

  // Clear count and output valid on reset; advance them per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q <= count_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      top_q     <= top_d;
      cnt_out_q <= cnt_ext[COUNT_OUT_W-1:0];
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tuser  = status_q;
  assign m_tdata  = {2'b00, top_q, cnt_out_q, removed_q};

  // Insert into a full queue reports overflow
  `MHPQ_ASSERT_NEXT(a_overflow, clk_i, rst_ni,
                    in_acc && (s_tuser == KIND_INSERT) && full,
                    m_tuser == STATUS_OVERFLOW)
  // A successful delete drops the count by one
  `MHPQ_ASSERT_NEXT(a_del_count, clk_i, rst_ni,
                    in_acc && (s_tuser == KIND_DELETE) && !empty,
                    count_q == $past(count_q) - 1'b1)
  // An empty result shows a zero top
  `MHPQ_ASSERT_IMPLY(a_empty_top, clk_i, rst_ni,
                     m_tvalid && (m_tdata[37:32] == 6'd0) && (CAPACITY < 64),
                     m_tdata[69:38] == 32'd0)

endmodule

// File: rtl/core/mhpq_cell.sv
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
module mhpq_cell
  import mhpq_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      occ_i,
  input  cell_op_t                  op_i,
  input  logic                      left_ge_i,
  input  logic signed [VALUE_W-1:0] left_val_i,
  input  logic signed [VALUE_W-1:0] right_val_i,
  output logic                      ge_o,
  output logic signed [VALUE_W-1:0] val_q_o,
  output logic signed [VALUE_W-1:0] val_d_o
);

  logic signed [VALUE_W-1:0] val_q, val_d;

  // Occupied and not below the new value: this cell keeps its entry on insert
  assign ge_o = occ_i && (val_q >= op_i.value);

  // Pick next entry: keep, take the new value, or take the left neighbor's
  always_comb begin
    val_d = val_q;
    if (op_i.ins) begin
      if (!ge_o) begin
        val_d = left_ge_i ? op_i.value : left_val_i;
      end
    end else if (op_i.del) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_q_o = val_q;
  assign val_d_o = val_d;

endmodule

// File: verif/max_heap_priority_queue_tb.sv
// Self-checking testbench for the max heap priority queue: stream driver, monitor, heap predictor.
module max_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int RAND_ITEMS  = 1650;
  localparam int QUIET_TAIL  = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int STALL_AT    = 300;
  localparam int STALL_LEN   = 160;

  // One pending operation; wait_idle holds it back until all results are in
  typedef struct {
    logic                kind;
    logic [VALUE_W-1:0]  value;
    bit                  wait_idle;
  } heap_op_t;

  // One predicted result
  typedef struct {
    status_e                   status;
    logic signed [VALUE_W-1:0] removed;
    logic [COUNT_OUT_W-1:0]    count;
    logic signed [VALUE_W-1:0] top;
  } heap_result_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;  // [31:0] value
  logic        s_tuser  = 1'b0;  // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;  // [31:0] removed_value, [37:32] entry_count, [69:38] top_value, [71:70] zero
  logic [1:0]  m_tuser;  // [1:0] status

  heap_op_t     op_q[$];
  heap_result_t result_q[$];
  int           total_ops = 0;
  int           sent_cnt  = 0;
  int           got_cnt   = 0;
  int           err_cnt   = 0;
  int           cyc_cnt   = 0;

  // Predictor state
  logic signed [VALUE_W-1:0] heap_mem [CAP];
  int                        heap_cnt = 0;

  max_heap_priority_queue i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Apply one operation to the heap copy and return the result it yields
  function automatic heap_result_t heap_apply(logic kind, logic signed [VALUE_W-1:0] value);
    heap_result_t              res;
    int                        pos;
    int                        up;
    int                        best;
    int                        lft;
    int                        rgt;
    logic signed [VALUE_W-1:0] tmp;
    res.status  = STATUS_DONE;
    res.removed = '0;
    if (kind == KIND_INSERT) begin
      if (heap_cnt >= CAP) begin
        res.status = STATUS_OVERFLOW;
      end else begin
        heap_mem[heap_cnt] = value;
        pos = heap_cnt;
        heap_cnt++;
        // sift up while the parent is strictly smaller
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_mem[up] < heap_mem[pos])) break;
          tmp           = heap_mem[up];
          heap_mem[up]  = heap_mem[pos];
          heap_mem[pos] = tmp;
          pos = up;
        end
      end
    end else begin
      if (heap_cnt == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.removed = heap_mem[0];
        heap_mem[0] = heap_mem[heap_cnt-1];
        heap_cnt--;
        pos = 0;
        // sift down toward a strictly larger child, left preferred on ties
        forever begin
          best = pos;
          lft  = 2 * pos + 1;
          rgt  = 2 * pos + 2;
          if (lft < heap_cnt && heap_mem[best] < heap_mem[lft]) best = lft;
          if (rgt < heap_cnt && heap_mem[best] < heap_mem[rgt]) best = rgt;
          if (best == pos) break;
          tmp            = heap_mem[best];
          heap_mem[best] = heap_mem[pos];
          heap_mem[pos]  = tmp;
          pos = best;
        end
      end
    end
    res.count = heap_cnt[COUNT_OUT_W-1:0];
    res.top   = (heap_cnt > 0) ? heap_mem[0] : '0;
    return res;
  endfunction

  // Pick a value: extremes, a narrow band for duplicates, or full random
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_op(logic kind, logic [VALUE_W-1:0] value, bit wait_idle = 0);
    heap_op_t op;
    op.kind      = kind;
    op.value     = value;
    op.wait_idle = wait_idle;
    op_q.push_back(op);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Drive input items from the pending queue, with random gaps
  int src_gap = 0;
  always @(posedge clk_i) begin
    heap_op_t op;
    bit       busy;
    bit       blocked;
    if (rst_ni) begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        result_q.push_back(heap_apply(s_tuser, s_tdata));
        sent_cnt++;
        busy = 1'b0;
      end
      if (!busy) begin
        blocked = op_q.size() == 0 || (op_q[0].wait_idle && result_q.size() != 0);
        if (src_gap > 0) begin
          src_gap--;
        end else if (!blocked) begin
          op = op_q.pop_front();
          s_tdata <= op.value;
          s_tuser <= op.kind;
          busy = 1'b1;
          if (sent_cnt < total_ops - QUIET_TAIL && $urandom_range(0, 7) == 0)
            src_gap = $urandom_range(1, 11);
        end
      end
      s_tvalid <= busy;
    end
  end

  // Accept and check result items; random stalls plus one long hold-off
  int  sink_gap   = 0;
  int  sink_stall = 0;
  bit  stall_done = 0;
  always @(posedge clk_i) begin
    heap_result_t exp_r;
    bit           rdy;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h/%h",
                   $time, m_tuser, m_tdata);
          err_cnt++;
        end else begin
          exp_r = result_q.pop_front();
          check_field("status", 32'(exp_r.status), 32'(m_tuser));
          check_field("removed_value", exp_r.removed, m_tdata[31:0]);
          check_field("entry_count", 32'(exp_r.count), 32'(m_tdata[37:32]));
          check_field("top_value", exp_r.top, m_tdata[69:38]);
        end
        got_cnt++;
      end
      rdy = 1'b1;
      if (!stall_done && got_cnt == STALL_AT) begin
        stall_done = 1;
        sink_stall = STALL_LEN;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        rdy = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        rdy = 1'b0;
      end else if (got_cnt < total_ops - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 11);
        rdy = 1'b0;
      end
      m_tready <= rdy;
    end
  end

  // Guard against a hang
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Build stimulus, release reset, wait for the drain and report
  initial begin
    int mode;
    int seg_len;
    int n;
    int ins_pct;
    // directed: extremes, empty delete, duplicates
    add_op(KIND_DELETE, $urandom());
    add_op(KIND_INSERT, 32'h0000_0000);
    add_op(KIND_DELETE, 32'hffff_ffff);
    add_op(KIND_DELETE, 32'h0000_0000);
    add_op(KIND_INSERT, 32'h8000_0000);
    add_op(KIND_INSERT, 32'h7fff_ffff);
    add_op(KIND_INSERT, 32'hffff_ffff);
    add_op(KIND_INSERT, 32'h0000_0001);
    add_op(KIND_INSERT, 32'h0000_0005);
    add_op(KIND_INSERT, 32'h0000_0005);
    add_op(KIND_INSERT, 32'h0000_0005);
    add_op(KIND_INSERT, 32'h8000_0000);
    add_op(KIND_INSERT, 32'h7fff_ffff);
    for (int i = 0; i < 10; i++) add_op(KIND_DELETE, $urandom());
    add_op(KIND_DELETE, $urandom());
    // random: segments biased to fill, mix or drain the heap
    n = 0;
    while (n < RAND_ITEMS) begin
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(30, 80);
      ins_pct = (mode == 0) ? 90 : (mode == 1) ? 50 : 15;
      for (int i = 0; i < seg_len && n < RAND_ITEMS; i++) begin
        add_op(($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_DELETE, pick_value(),
               i == 0 && (n == 0 || $urandom_range(0, 5) == 0));
        n++;
      end
    end
    total_ops = op_q.size();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (sent_cnt == total_ops);
    wait (result_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
